// ----- hdl/rfq_pkg.sv -----
package rfq_pkg;

	localparam int DEF_SLOTS      = 16;
	localparam int DEF_SLOT_BYTES = 64;

	localparam int REQ_W    = 2;
	localparam int KEY_W    = 32;
	localparam int STAMP_W  = 64;
	localparam int BYTE_W   = 8;
	localparam int SPACE_W  = 16;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 5;
	localparam int SIZE_W   = 7;
	localparam int MAXREC_W = 5;

	localparam logic [MAXREC_W-1:0] MAX_RECORDS_RESET = 5'd16;

	typedef enum logic [REQ_W-1:0] {
		REQ_ADD  = 2'd0,
		REQ_PEEK = 2'd1,
		REQ_POP  = 2'd2,
		REQ_LEN  = 2'd3
	} req_t;

	localparam logic [STATUS_W-1:0] STAT_OK    = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_SPACE = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_TRUNC = 3'd4;

	// per-slot record descriptor
	typedef struct packed {
		logic [SIZE_W-1:0]  size;
		logic [KEY_W-1:0]   key;
		logic [STAMP_W-1:0] stamp;
	} desc_t;

	localparam int DESC_W = $bits(desc_t);

endpackage

// ----- hdl/rfq_ram.sv -----
module rfq_ram #(
	parameter int DEPTH = rfq_pkg::DEF_SLOTS,
	parameter int WIDTH = rfq_pkg::BYTE_W,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/record_fifo_queue_unit.sv -----
// Bounded queue of byte records held in fixed slots. Adds, pops, length queries and peeks
// of an empty queue are taken one per cycle while the block is idle and answer with one
// result strobe in the cycle after the transfer (an add byte that is not the last gives no
// result). Any other peek holds busy while the head descriptor read at the transfer is
// checked in the check state. With too little reader space the check state answers with one
// result. Otherwise it streams the head record one byte per cycle from the payload memory,
// the bytes following the check state; busy stays high through the cycle that carries the
// final byte. Results are presented for one cycle only; the receiver cannot stall, so it
// must take every strobe. max_records may only be written while the block is idle.
module record_fifo_queue_unit #(
	parameter int SLOTS      = rfq_pkg::DEF_SLOTS,
	parameter int SLOT_BYTES = rfq_pkg::DEF_SLOT_BYTES
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [rfq_pkg::REQ_W-1:0]      req_type,
	input  logic [rfq_pkg::KEY_W-1:0]      record_key,
	input  logic [rfq_pkg::STAMP_W-1:0]    record_time,
	input  logic [rfq_pkg::BYTE_W-1:0]     data_byte,
	input  logic                           byte_last,
	input  logic [rfq_pkg::SPACE_W-1:0]    reader_space,
	input  logic                           cfg_wr_en,
	input  logic [rfq_pkg::MAXREC_W-1:0]   cfg_wr_data,
	output logic                           result_strobe,
	output logic [rfq_pkg::STATUS_W-1:0]   status,
	output logic [rfq_pkg::COUNT_W-1:0]    count,
	output logic [rfq_pkg::SIZE_W-1:0]     head_size,
	output logic [rfq_pkg::KEY_W-1:0]      out_key,
	output logic [rfq_pkg::STAMP_W-1:0]    out_time,
	output logic [rfq_pkg::BYTE_W-1:0]     out_byte,
	output logic                           last
);

	localparam int SW   = $clog2(SLOTS);
	localparam int CW   = $clog2(SLOTS + 1);
	localparam int CAPW = (CW > rfq_pkg::MAXREC_W) ? CW : rfq_pkg::MAXREC_W;
	localparam int OW   = $clog2(SLOT_BYTES + 1);
	localparam int PD   = SLOTS * SLOT_BYTES;
	localparam int PAW  = $clog2(PD);

	localparam logic [PAW-1:0]  SB_A     = PAW'(SLOT_BYTES);
	localparam logic [OW-1:0]   SB_O     = OW'(SLOT_BYTES);
	localparam logic [CAPW-1:0] SLOTS_C  = CAPW'(SLOTS);
	localparam logic [SW-1:0]   SLOT_TOP = SW'(SLOTS - 1);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_CHK    = 3'b010,
		ST_STREAM = 3'b100
	} state_t;

	state_t                          state_q;
	logic [rfq_pkg::MAXREC_W-1:0]    max_q;
	logic [SW-1:0]                   head_q;
	logic [SW-1:0]                   tail_q;
	logic [CW-1:0]                   held_q;
	logic [OW-1:0]                   fill_q;
	logic                            rej_q;
	logic                            trunc_q;
	logic [OW-1:0]                   rd_idx_q;
	logic [rfq_pkg::SPACE_W-1:0]     space_q;

	logic                            strobe_q;
	logic                            byte_en_q;
	logic [rfq_pkg::STATUS_W-1:0]    status_q;
	logic [rfq_pkg::COUNT_W-1:0]     count_q;
	logic [rfq_pkg::SIZE_W-1:0]      size_q;
	logic [rfq_pkg::KEY_W-1:0]       key_q;
	logic [rfq_pkg::STAMP_W-1:0]     stamp_q;
	logic                            last_q;

	rfq_pkg::req_t                   req;
	logic [CAPW-1:0]                 cap_w;
	logic [CAPW-1:0]                 held_w;
	logic [CAPW-1:0]                 held_inc;
	logic [CAPW-1:0]                 held_dec;
	logic                            rej_now;
	logic                            room;
	logic [OW-1:0]                   size_commit;
	logic                            trunc_commit;
	logic [SW-1:0]                   tail_next;
	logic [SW-1:0]                   head_next;

	logic                            pay_we;
	logic [PAW-1:0]                  pay_waddr;
	logic [PAW-1:0]                  pay_raddr;
	logic [rfq_pkg::BYTE_W-1:0]      pay_rd;
	logic                            desc_we;
	rfq_pkg::desc_t                  desc_wr;
	logic [rfq_pkg::DESC_W-1:0]      desc_rd_raw;
	rfq_pkg::desc_t                  desc_rd;

	assign busy = (state_q != ST_IDLE);
	assign req  = rfq_pkg::req_t'(req_type);

	always_comb begin
		held_w       = CAPW'(held_q);
		held_inc     = held_w + CAPW'(1);
		held_dec     = held_w - CAPW'(1);
		cap_w        = (CAPW'(max_q) < SLOTS_C) ? CAPW'(max_q) : SLOTS_C;
		rej_now      = rej_q | ((fill_q == '0) & (held_w >= cap_w));
		room         = (fill_q < SB_O);
		size_commit  = (!rej_now && room) ? (fill_q + OW'(1)) : fill_q;
		trunc_commit = trunc_q | (!rej_now & !room);
		tail_next    = (tail_q == SLOT_TOP) ? '0 : (tail_q + SW'(1));
		head_next    = (head_q == SLOT_TOP) ? '0 : (head_q + SW'(1));
	end

	assign pay_we    = start & ~busy & (req == rfq_pkg::REQ_ADD) & ~rej_now & room;
	assign pay_waddr = PAW'(tail_q) * SB_A + PAW'(fill_q);
	assign pay_raddr = PAW'(head_q) * SB_A + PAW'(rd_idx_q);

	assign desc_we       = start & ~busy & (req == rfq_pkg::REQ_ADD) & byte_last & ~rej_now;
	assign desc_wr.size  = rfq_pkg::SIZE_W'(size_commit);
	assign desc_wr.key   = record_key;
	assign desc_wr.stamp = record_time;
	assign desc_rd       = rfq_pkg::desc_t'(desc_rd_raw);

	rfq_ram #(
		.DEPTH (PD),
		.WIDTH (rfq_pkg::BYTE_W),
		.AW    (PAW)
	) u_pay_ram (
		.clk   (clk),
		.we    (pay_we),
		.waddr (pay_waddr),
		.wdata (data_byte),
		.raddr (pay_raddr),
		.rdata (pay_rd)
	);

	rfq_ram #(
		.DEPTH (SLOTS),
		.WIDTH (rfq_pkg::DESC_W),
		.AW    (SW)
	) u_desc_ram (
		.clk   (clk),
		.we    (desc_we),
		.waddr (tail_q),
		.wdata (desc_wr),
		.raddr (head_q),
		.rdata (desc_rd_raw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			max_q     <= rfq_pkg::MAX_RECORDS_RESET;
			head_q    <= '0;
			tail_q    <= '0;
			held_q    <= '0;
			fill_q    <= '0;
			rej_q     <= 1'b0;
			trunc_q   <= 1'b0;
			rd_idx_q  <= '0;
			space_q   <= '0;
			strobe_q  <= 1'b0;
			byte_en_q <= 1'b0;
			status_q  <= rfq_pkg::STAT_OK;
			count_q   <= '0;
			size_q    <= '0;
			key_q     <= '0;
			stamp_q   <= '0;
			last_q    <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				max_q <= cfg_wr_data;
			end
			strobe_q  <= 1'b0;
			byte_en_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						size_q  <= '0;
						key_q   <= '0;
						stamp_q <= '0;
						last_q  <= 1'b1;
						count_q <= held_w[rfq_pkg::COUNT_W-1:0];
						case (req)
							rfq_pkg::REQ_ADD: begin
								if (!byte_last) begin
									rej_q <= rej_now;
									if (!rej_now) begin
										if (room) begin
											fill_q <= fill_q + OW'(1);
										end else begin
											trunc_q <= 1'b1;
										end
									end
								end else begin
									rej_q    <= 1'b0;
									fill_q   <= '0;
									trunc_q  <= 1'b0;
									strobe_q <= 1'b1;
									if (rej_now) begin
										status_q <= rfq_pkg::STAT_FULL;
									end else begin
										status_q <= trunc_commit ? rfq_pkg::STAT_TRUNC
											: rfq_pkg::STAT_OK;
										tail_q   <= tail_next;
										held_q   <= held_q + CW'(1);
										count_q  <= held_inc[rfq_pkg::COUNT_W-1:0];
									end
								end
							end
							rfq_pkg::REQ_PEEK: begin
								if (held_q == '0) begin
									strobe_q <= 1'b1;
									status_q <= rfq_pkg::STAT_EMPTY;
								end else begin
									space_q  <= reader_space;
									rd_idx_q <= '0;
									state_q  <= ST_CHK;
								end
							end
							rfq_pkg::REQ_POP: begin
								strobe_q <= 1'b1;
								if (held_q == '0) begin
									status_q <= rfq_pkg::STAT_EMPTY;
								end else begin
									status_q <= rfq_pkg::STAT_OK;
									head_q   <= head_next;
									held_q   <= held_q - CW'(1);
									count_q  <= held_dec[rfq_pkg::COUNT_W-1:0];
								end
							end
							default: begin
								strobe_q <= 1'b1;
								status_q <= rfq_pkg::STAT_OK;
							end
						endcase
					end
				end
				ST_CHK: begin
					strobe_q <= 1'b1;
					size_q   <= desc_rd.size;
					count_q  <= held_w[rfq_pkg::COUNT_W-1:0];
					if (space_q < rfq_pkg::SPACE_W'(desc_rd.size)) begin
						status_q <= rfq_pkg::STAT_SPACE;
						key_q    <= '0;
						stamp_q  <= '0;
						last_q   <= 1'b1;
						state_q  <= ST_IDLE;
					end else begin
						status_q  <= rfq_pkg::STAT_OK;
						key_q     <= desc_rd.key;
						stamp_q   <= desc_rd.stamp;
						byte_en_q <= 1'b1;
						last_q    <= (desc_rd.size == rfq_pkg::SIZE_W'(1));
						rd_idx_q  <= rd_idx_q + OW'(1);
						state_q   <= ST_STREAM;
					end
				end
				ST_STREAM: begin
					if (rfq_pkg::SIZE_W'(rd_idx_q) == size_q) begin
						state_q <= ST_IDLE;
					end else begin
						strobe_q  <= 1'b1;
						byte_en_q <= 1'b1;
						last_q    <= ((rfq_pkg::SIZE_W'(rd_idx_q) + rfq_pkg::SIZE_W'(1))
							== size_q);
						rd_idx_q  <= rd_idx_q + OW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_strobe = strobe_q;
	assign status        = status_q;
	assign count         = count_q;
	assign head_size     = size_q;
	assign out_key       = key_q;
	assign out_time      = stamp_q;
	assign out_byte      = byte_en_q ? pay_rd : '0;
	assign last          = last_q;

endmodule
